[src/pll_frequency_word_calc_unit_defines.svh]
// assertion macros shared by the frequency word calculator
`ifndef PLL_FREQUENCY_WORD_CALC_UNIT_DEFINES_SVH
`define PLL_FREQUENCY_WORD_CALC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PLLFW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pllfw assertion failed");
// next-cycle implication
`define PLLFW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pllfw assertion failed");
`else
`define PLLFW_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLLFW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[src/pllfw_pkg.sv]
`timescale 1ns / 1ps
package pllfw_pkg;

  localparam int FREQ_W    = 16;
  localparam int PFD_W     = 10;
  localparam int WORD_W    = 32;
  localparam int K_W       = 3;
  localparam int M_W       = 13;
  localparam int V_W       = 17;
  localparam int FRAC_W    = 10;
  localparam int MOD_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_MAX_I = 6;
  localparam int VCO_W     = M_W + DIV_MAX_I;
  localparam int FV_W      = FREQ_W + DIV_MAX_I;
  localparam logic [K_W-1:0] DIV_MAX = K_W'(DIV_MAX_I);

  localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd350;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd44000;
  localparam logic [VCO_W-1:0]  VCO_MIN  = VCO_W'(2200);
  localparam logic [VCO_W-1:0]  VCO_MAX  = VCO_W'(4400);

  // f / 10 as (f * 52429) >> 19, exact over 16 bits
  localparam logic [FREQ_W-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SH = 19;
  // x / 5 as (x * 13108) >> 16, exact over 10 bits
  localparam int DIV5_MUL_W = 14;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 14'd13108;
  localparam int DIV5_SH = 16;
  localparam int Q5_W = FRAC_W + DIV5_MUL_W - DIV5_SH;

  localparam logic [PFD_W-1:0] FRAC_SCALE = 10'd1000;
  localparam logic [MOD_W-1:0] MOD_START  = 10'd1000;

  localparam logic [PFD_W-1:0]  PFD_RESET    = 10'd250;
  localparam logic [WORD_W-1:0] R1_RESET     = 32'd32769;
  localparam logic [WORD_W-1:0] R4_RESET     = 32'd9207868;
  localparam logic [WORD_W-1:0] RF_OFF_RESET = 32'd9207836;

  localparam int MOD_SH  = 3;
  localparam int INT_SH  = 15;
  localparam int FRAC_SH = 3;
  localparam int K_SH    = 20;

  // divider pipeline: restoring steps per register stage
  localparam int SPS         = 4;
  localparam int INT_STAGES  = (V_W + SPS - 1) / SPS;
  localparam int FRAC_STAGES = (FRAC_W + SPS - 1) / SPS;
  localparam int DIV_STAGES  = INT_STAGES + 1 + FRAC_STAGES;

  // modulus reduction: factor-of-five steps, then one power-of-two stage, then words
  localparam int FIVE_STEPS  = 3;
  localparam int PACK_STAGES = FIVE_STEPS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PFD,
    CFG_R1_BASE,
    CFG_R4_ON,
    CFG_RF_OFF
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BEAT_RF_OFF,
    BEAT_R1,
    BEAT_R0,
    BEAT_R4
  } beat_t;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic [V_W-1:0] v;
  } vco_item_t;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [V_W-1:0]    int_w;
    logic [FRAC_W-1:0] frac;
  } div_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w4;
  } word_set_t;

endpackage

[src/pllfw_prep.sv]
`timescale 1ns / 1ps
module pllfw_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pllfw_pkg::FREQ_W-1:0]  in_freq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pllfw_pkg::vco_item_t          out_data
);
  import pllfw_pkg::*;

  logic a_vld, b_vld;
  logic a_load, b_load;
  logic [FREQ_W-1:0] f_clamp;
  logic [2*FREQ_W-1:0] m_prod;
  logic [FREQ_W-1:0] a_freq;
  logic [M_W-1:0] a_mhz;
  logic [DIV_MAX_I:0] fit;
  logic [K_W-1:0] k_sel;
  logic [FV_W-1:0] v_wide;
  vco_item_t b_next, b_data;

  assign b_load   = !b_vld || out_ready;
  assign a_load   = !a_vld || b_load;
  assign in_ready = a_load;

  // clamp, then integer MHz by reciprocal multiply
  always_comb begin
    f_clamp = in_freq;
    if (in_freq < FREQ_MIN) begin
      f_clamp = FREQ_MIN;
    end else if (in_freq > FREQ_MAX) begin
      f_clamp = FREQ_MAX;
    end
    m_prod = f_clamp * DIV10_MUL;
  end

  // smallest divider that lands the vco in band
  always_comb begin
    logic [VCO_W-1:0] vco;
    vco = '0;
    for (int i = 0; i <= DIV_MAX_I; i++) begin
      vco = VCO_W'(a_mhz) << i;
      fit[i] = (vco >= VCO_MIN) && (vco <= VCO_MAX);
    end
    k_sel = DIV_MAX;
    for (int i = DIV_MAX_I; i >= 0; i--) begin
      if (fit[i]) k_sel = K_W'(i);
    end
    v_wide = FV_W'(a_freq) << k_sel;
    b_next.k = k_sel;
    b_next.v = v_wide[V_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (a_load) a_vld <= in_valid;
      if (b_load) b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_freq <= f_clamp;
      a_mhz  <= m_prod[DIV10_SH +: M_W];
    end
    if (b_load) b_data <= b_next;
  end

  assign out_valid = b_vld;
  assign out_data  = b_data;

endmodule

[src/pllfw_div.sv]
`timescale 1ns / 1ps
module pllfw_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pllfw_pkg::PFD_W-1:0]  pfd,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pllfw_pkg::vco_item_t         in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pllfw_pkg::div_item_t         out_data
);
  import pllfw_pkg::*;

  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [V_W-1:0]   int_w;
    logic [PFD_W-1:0] rem;
    logic [V_W-1:0]   acc;
  } div_stage_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [PFD_W:0] div_step(input logic [PFD_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [PFD_W-1:0] divisor);
    logic [PFD_W:0] trial;
    logic [PFD_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      div_step = {1'b1, diff[PFD_W-1:0]};
    end else begin
      div_step = {1'b0, trial[PFD_W-1:0]};
    end
  endfunction

  div_stage_t src [DIV_STAGES];
  div_stage_t nxt [DIV_STAGES];
  div_stage_t st  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   rdy;

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready = rdy[0];
  assign src[0] = '{k: in_data.k, int_w: '0, rem: '0, acc: in_data.v};

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    assign rdy[s] = !vld[s] || rdy[s+1];

    if (s > 0) begin : g_link
      assign src[s] = st[s-1];
    end

    if (s < INT_STAGES) begin : g_int
      // quotient bits of v / pfd, msb first
      always_comb begin
        logic [PFD_W:0] r;
        r = '0;
        nxt[s] = src[s];
        for (int t = 0; t < SPS; t++) begin
          if (s * SPS + t < V_W) begin
            r = div_step(nxt[s].rem, nxt[s].acc[V_W-1], pfd);
            nxt[s].rem = r[PFD_W-1:0];
            nxt[s].acc = {nxt[s].acc[V_W-2:0], r[PFD_W]};
          end
        end
      end
    end else if (s == INT_STAGES) begin : g_scale
      // remainder times 1000; top part is already below pfd
      always_comb begin
        logic [2*PFD_W-1:0] prod;
        prod = src[s].rem * FRAC_SCALE;
        nxt[s] = src[s];
        nxt[s].int_w = src[s].acc;
        nxt[s].rem   = prod[FRAC_W +: PFD_W];
        nxt[s].acc   = V_W'(prod[FRAC_W-1:0]);
      end
    end else begin : g_frac
      always_comb begin
        logic [PFD_W:0] r;
        r = '0;
        nxt[s] = src[s];
        for (int t = 0; t < SPS; t++) begin
          if ((s - INT_STAGES - 1) * SPS + t < FRAC_W) begin
            r = div_step(nxt[s].rem, nxt[s].acc[FRAC_W-1], pfd);
            nxt[s].rem = r[PFD_W-1:0];
            nxt[s].acc[FRAC_W-1:0] = {nxt[s].acc[FRAC_W-2:0], r[PFD_W]};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) st[s] <= nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
    end
  end

  assign out_valid      = vld[DIV_STAGES-1];
  assign out_data.k     = st[DIV_STAGES-1].k;
  assign out_data.int_w = st[DIV_STAGES-1].int_w;
  assign out_data.frac  = st[DIV_STAGES-1].acc[FRAC_W-1:0];

endmodule

[src/pllfw_pack.sv]
`timescale 1ns / 1ps
module pllfw_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pllfw_pkg::WORD_W-1:0]  r1_base,
  input  logic [pllfw_pkg::WORD_W-1:0]  r4_on,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pllfw_pkg::div_item_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pllfw_pkg::word_set_t          out_data
);
  import pllfw_pkg::*;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [V_W-1:0]    int_w;
    logic [FRAC_W-1:0] x;
    logic [1:0]        c5;
  } five_stage_t;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [V_W-1:0]    int_w;
    logic [FRAC_W-1:0] frac;
    logic [MOD_W-1:0]  modw;
  } red_stage_t;

  five_stage_t f_src [FIVE_STEPS];
  five_stage_t f_nxt [FIVE_STEPS];
  five_stage_t f_st  [FIVE_STEPS];
  red_stage_t  t_nxt, t_st;
  word_set_t   w_nxt, w_st;
  logic [MOD_W-1:0] mod5;
  logic [1:0] tz;
  logic [PACK_STAGES-1:0] vld;
  logic [PACK_STAGES:0]   rdy;

  assign rdy[PACK_STAGES] = out_ready;
  for (genvar s = 0; s < PACK_STAGES; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_ready = rdy[0];

  assign f_src[0] = '{k: in_data.k, int_w: in_data.int_w, x: in_data.frac, c5: '0};

  // one factor of five per stage while frac allows it
  for (genvar s = 0; s < FIVE_STEPS; s++) begin : g_five
    if (s > 0) begin : g_link
      assign f_src[s] = f_st[s-1];
    end

    always_comb begin
      logic [FRAC_W+DIV5_MUL_W-1:0] prod;
      logic [FRAC_W-1:0] q;
      logic [FRAC_W-1:0] q5;
      prod = f_src[s].x * DIV5_MUL;
      q    = FRAC_W'(prod[DIV5_SH +: Q5_W]);
      q5   = (q << 2) + q;
      f_nxt[s] = f_src[s];
      if (q5 == f_src[s].x) begin
        f_nxt[s].x  = q;
        f_nxt[s].c5 = f_src[s].c5 + 2'd1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) f_st[s] <= f_nxt[s];
    end
  end

  // modulus after the fives, then up to three factors of two
  always_comb begin
    case (f_st[FIVE_STEPS-1].c5)
      2'd0:    mod5 = MOD_START;
      2'd1:    mod5 = MOD_START / 5;
      2'd2:    mod5 = MOD_START / 25;
      2'd3:    mod5 = MOD_START / 125;
      default: mod5 = MOD_START;
    endcase
    if (f_st[FIVE_STEPS-1].x[0]) begin
      tz = 2'd0;
    end else if (f_st[FIVE_STEPS-1].x[1]) begin
      tz = 2'd1;
    end else if (f_st[FIVE_STEPS-1].x[2]) begin
      tz = 2'd2;
    end else begin
      tz = 2'd3;
    end
    t_nxt.k     = f_st[FIVE_STEPS-1].k;
    t_nxt.int_w = f_st[FIVE_STEPS-1].int_w;
    t_nxt.frac  = f_st[FIVE_STEPS-1].x >> tz;
    t_nxt.modw  = mod5 >> tz;
  end

  always_comb begin
    w_nxt.w1 = r1_base + (WORD_W'(t_st.modw) << MOD_SH);
    w_nxt.w0 = (WORD_W'(t_st.int_w) << INT_SH) + (WORD_W'(t_st.frac) << FRAC_SH);
    w_nxt.w4 = r4_on + (WORD_W'(t_st.k) << K_SH);
  end

  always_ff @(posedge clk) begin
    if (rdy[FIVE_STEPS]) t_st <= t_nxt;
    if (rdy[FIVE_STEPS+1]) w_st <= w_nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int s = 1; s < PACK_STAGES; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
    end
  end

  assign out_valid = vld[PACK_STAGES-1];
  assign out_data  = w_st;

endmodule

[src/pllfw_ser.sv]
`timescale 1ns / 1ps
`include "pll_frequency_word_calc_unit_defines.svh"
module pllfw_ser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pllfw_pkg::WORD_W-1:0]  rf_off_word,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pllfw_pkg::word_set_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pllfw_pkg::WORD_W-1:0]  out_word,
  output logic                          out_last
);
  import pllfw_pkg::*;

  logic full;
  beat_t beat;
  word_set_t words;

  assign in_ready = !full || (out_ready && beat == BEAT_R4);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      beat <= BEAT_RF_OFF;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
      beat <= BEAT_RF_OFF;
    end else if (full && out_ready) begin
      if (beat == BEAT_R4) begin
        full <= 1'b0;
        beat <= BEAT_RF_OFF;
      end else begin
        beat <= beat_t'(beat + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) words <= in_data;
  end

  always_comb begin
    case (beat)
      BEAT_RF_OFF: out_word = rf_off_word;
      BEAT_R1:     out_word = words.w1;
      BEAT_R0:     out_word = words.w0;
      BEAT_R4:     out_word = words.w4;
      default:     out_word = rf_off_word;
    endcase
  end

  assign out_valid = full;
  assign out_last  = (beat == BEAT_R4);

  `PLLFW_ASSERT_NXT(a_stall_holds_beat, clk, rst, full && !out_ready, full && $stable(beat))
  `PLLFW_ASSERT_IMP(a_load_when_free, clk, rst, in_valid && in_ready, !full || (out_ready && beat == BEAT_R4))
  `PLLFW_ASSERT_NXT(a_last_wraps, clk, rst, full && out_ready && beat == BEAT_R4, beat == BEAT_RF_OFF)

endmodule

[src/pll_frequency_word_calc_unit.sv]
`timescale 1ns / 1ps
// frequency word calculator for a fractional-n synthesizer
// s_axis: one transfer per request, tdata[15:0] = wanted frequency in 0.1 MHz
// m_axis: four transfers per request, in order: rf-off word, register 1 word
//   (base + modulus), register 0 word (int and frac), register 4 word (base +
//   divider select); tlast marks the fourth word
// cfg port: cfg_we / cfg_index / cfg_wdata write pfd, r1 base, r4 base and the
//   rf-off word; write only while no request is in flight
// pipeline: a request passes 2 prep stages, 9 divider stages, 5 packing stages and the
//   output register before its first word is valid on m_axis
// throughput: a new request every cycle enters the pipeline while it is not stalled; the
//   sustained rate is set by the four words leaving on one output channel
// reset: clears all valid bits and loads the register defaults (pfd 25.0 MHz)
// stall: m_axis_tready low freezes the current word; the pipeline keeps filling
//   behind it and then drops s_axis_tready, nothing is lost or repeated
module pll_frequency_word_calc_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pllfw_pkg::FREQ_W-1:0]      s_axis_tdata,   // [15:0] freq_tenths
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pllfw_pkg::WORD_W-1:0]      m_axis_tdata,   // [31:0] reg_word
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [pllfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pllfw_pkg::WORD_W-1:0]      cfg_wdata
);
  import pllfw_pkg::*;

  // config registers; pfd is kept already forced nonzero
  logic [PFD_W-1:0]  pfd_eff;
  logic [WORD_W-1:0] r1_base;
  logic [WORD_W-1:0] r4_on;
  logic [WORD_W-1:0] rf_off_word;

  // stream links between the pipeline sections
  logic      prep_valid, prep_ready;
  vco_item_t prep_data;
  logic      div_valid, div_ready;
  div_item_t div_data;
  logic      pack_valid, pack_ready;
  word_set_t pack_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfd_eff     <= PFD_RESET;
      r1_base     <= R1_RESET;
      r4_on       <= R4_RESET;
      rf_off_word <= RF_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PFD: begin
          // a zero reference is taken as one tenth of a MHz
          if (cfg_wdata[PFD_W-1:0] == '0) begin
            pfd_eff <= PFD_W'(1);
          end else begin
            pfd_eff <= cfg_wdata[PFD_W-1:0];
          end
        end
        CFG_R1_BASE: r1_base     <= cfg_wdata;
        CFG_R4_ON:   r4_on       <= cfg_wdata;
        CFG_RF_OFF:  rf_off_word <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp, integer MHz, divider select, v = f << k
  pllfw_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_freq   (s_axis_tdata),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  // INT = v / pfd, FRAC = (rem * 1000) / pfd, a few restoring steps per stage
  pllfw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .pfd       (pfd_eff),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // reduce FRAC / MOD and build the register words
  pllfw_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .r1_base   (r1_base),
    .r4_on     (r4_on),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (pack_valid),
    .out_ready (pack_ready),
    .out_data  (pack_data)
  );

  // four-word output sequencer with its own holding register
  pllfw_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .rf_off_word (rf_off_word),
    .in_valid    (pack_valid),
    .in_ready    (pack_ready),
    .in_data     (pack_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_word    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

[dv/pll_frequency_word_calc_unit_tb.sv]
`timescale 1ns / 1ps
module pll_frequency_word_calc_unit_tb;
  import pllfw_pkg::*;

  // arithmetic limits of the synthesizer
  localparam int unsigned F_LOW      = 350;
  localparam int unsigned F_HIGH     = 44000;
  localparam int unsigned VCO_LOW    = 2200;
  localparam int unsigned VCO_HIGH   = 4400;
  localparam int unsigned FRAC_DEN   = 1000;
  localparam int          LAST_DIV_K = 6;
  localparam int          SETTLE_CYC = 40;

  // one expected register word on the output stream
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              is_last;
    beat_t             beat;
  } reg_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [FREQ_W-1:0]    s_axis_tdata;   // [15:0] freq_tenths
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [WORD_W-1:0]    m_axis_tdata;   // [31:0] reg_word
  logic                 m_axis_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  // shadow copy of the configuration registers
  logic [PFD_W-1:0]  pfd_shadow;
  logic [WORD_W-1:0] r1_base_shadow;
  logic [WORD_W-1:0] r4_on_shadow;
  logic [WORD_W-1:0] rf_off_shadow;

  // words still owed by the block, oldest first
  reg_beat_t pending_words[$];
  reg_beat_t head_word;

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  pll_frequency_word_calc_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // computes the four words for one request and queues them in output order
  function automatic void predict_words(input logic [FREQ_W-1:0] freq);
    logic [FREQ_W-1:0] f;
    logic [PFD_W-1:0]  pfd;
    logic [K_W-1:0]    k;
    logic [V_W-1:0]    v;
    logic [V_W-1:0]    int_w;
    logic [FRAC_W-1:0] frac;
    logic [MOD_W-1:0]  modulus;
    logic [63:0]       scaled;
    int unsigned       mhz;
    bit                found;
    reg_beat_t         rb;
    f = freq;
    // out-of-range requests are clamped, not rejected
    if (f < F_LOW) f = FREQ_W'(F_LOW);
    else if (f > F_HIGH) f = FREQ_W'(F_HIGH);
    // a zero reference would divide by zero, the block uses one instead
    pfd = (pfd_shadow == '0) ? PFD_W'(1) : pfd_shadow;
    // smallest power-of-two divider that lands the vco in band
    mhz = f / 10;
    k = K_W'(LAST_DIV_K);
    found = 1'b0;
    for (int i = 0; i <= LAST_DIV_K; i++) begin
      if (!found && (mhz << i) >= VCO_LOW && (mhz << i) <= VCO_HIGH) begin
        k = K_W'(i);
        found = 1'b1;
      end
    end
    v = V_W'(f) << k;
    int_w = v / pfd;
    scaled = (64'(v) * FRAC_DEN) / pfd;
    frac = FRAC_W'(scaled % FRAC_DEN);
    modulus = MOD_W'(FRAC_DEN);
    // reduce frac/mod by common fives, then common twos; zero frac ends at mod 1
    while (frac % 5 == 0 && modulus % 5 == 0) begin
      frac = FRAC_W'(frac / 5);
      modulus = MOD_W'(modulus / 5);
    end
    while (frac % 2 == 0 && modulus % 2 == 0) begin
      frac = FRAC_W'(frac / 2);
      modulus = MOD_W'(modulus / 2);
    end
    rb.is_last = 1'b0;
    rb.beat = BEAT_RF_OFF;
    rb.word = rf_off_shadow;
    pending_words.push_back(rb);
    rb.beat = BEAT_R1;
    rb.word = r1_base_shadow + (WORD_W'(modulus) << 3);
    pending_words.push_back(rb);
    rb.beat = BEAT_R0;
    rb.word = (WORD_W'(int_w) << 15) + (WORD_W'(frac) << 3);
    pending_words.push_back(rb);
    rb.is_last = 1'b1;
    rb.beat = BEAT_R4;
    rb.word = r4_on_shadow + (WORD_W'(k) << 20);
    pending_words.push_back(rb);
  endfunction

  // random request frequency, weighted toward the interesting regions
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned bounds[7] = '{690, 1380, 2750, 5500, 11000, 22000, 44000};
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return FREQ_W'($urandom_range(F_HIGH, F_LOW));
    if (sel < 75) return FREQ_W'(bounds[$urandom_range(6)] - 20 + $urandom_range(40));
    if (sel < 85) return FREQ_W'($urandom_range(F_LOW - 1, 0));
    if (sel < 95) return FREQ_W'($urandom_range(16'hFFFF, F_HIGH + 1));
    return FREQ_W'($urandom);
  endfunction

  // one request transfer; returns right after the accepting edge
  task automatic send_freq(input logic [FREQ_W-1:0] freq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= freq;
    do @(posedge clk); while (!s_axis_tready);
    predict_words(freq);
  endtask

  // stop offering and wait for every owed word
  task automatic drain_words();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // register write, only issued while nothing is in flight
  task automatic write_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_PFD:     pfd_shadow     = data[PFD_W-1:0];
      CFG_R1_BASE: r1_base_shadow = data;
      CFG_R4_ON:   r4_on_shadow   = data;
      CFG_RF_OFF:  rf_off_shadow  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // defaults: clamping at both ends, the divider boundaries from 1380 up, zero fraction
  task automatic test_clamp_and_dividers();
    logic [FREQ_W-1:0] freqs[18] = '{0, 349, 350, 351, 1379, 1380, 2749, 2750, 5499,
                                      5500, 10999, 11000, 21999, 22000, 44000, 44001,
                                      16'hFFFF, 25000};
    foreach (freqs[i]) send_freq(freqs[i]);
    drain_words();
  endtask

  // reference extremes: zero, top of range, full field, masked upper bits
  task automatic test_pfd_extremes();
    write_reg(CFG_PFD, '0);
    send_freq(16'd44000);
    send_freq(16'd12345);
    drain_words();
    write_reg(CFG_PFD, 32'd1023);
    send_freq(16'd350);
    drain_words();
    write_reg(CFG_PFD, 32'd1000);
    send_freq(16'd25001);
    drain_words();
    write_reg(CFG_PFD, 32'hFFFF_FC01);
    send_freq(16'd33333);
    drain_words();
  endtask

  // base words at all ones (sums wrap) and at zero
  task automatic test_base_words();
    write_reg(CFG_PFD, 32'd1);
    write_reg(CFG_R1_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_R4_ON, 32'hFFFF_FFFF);
    write_reg(CFG_RF_OFF, 32'hFFFF_FFFF);
    send_freq(16'd44000);
    drain_words();
    write_reg(CFG_R1_BASE, '0);
    write_reg(CFG_R4_ON, '0);
    write_reg(CFG_RF_OFF, '0);
    send_freq(16'd350);
    drain_words();
  endtask

  // long output hold-off while requests keep coming, so the input backs up
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_PFD, 32'd250);
    hold_left = 300;
    repeat (40) send_freq(pick_freq());
    drain_words();
  endtask

  // random requests in chunks, with a new random setting between chunks
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int unsigned sel;
    logic [WORD_W-1:0] raw;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        drain_words();
        raw = $urandom;
        sel = $urandom_range(9);
        if (sel == 0) write_reg(CFG_PFD, '0);
        else if (sel == 1) write_reg(CFG_PFD, 32'd1);
        else if (sel == 2) write_reg(CFG_PFD, {raw[31:PFD_W], PFD_W'(1023)});
        else write_reg(CFG_PFD, 32'($urandom_range(1000, 1)));
        if ($urandom_range(1)) write_reg(CFG_R1_BASE, $urandom);
        if ($urandom_range(1)) write_reg(CFG_R4_ON, $urandom);
        if ($urandom_range(1)) write_reg(CFG_RF_OFF, $urandom);
      end
      send_freq(pick_freq());
    end
    drain_words();
  endtask

  // output side: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compares every output transfer with the oldest owed word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("reg_word transfer with nothing owed: reg_word=%h tlast=%b",
               m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        head_word = pending_words.pop_front();
        if (m_axis_tdata !== head_word.word) begin
          $error("reg_word (%s): expected %h, got %h",
                 head_word.beat.name(), head_word.word, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== head_word.is_last) begin
          $error("last (%s): expected %b, got %b",
                 head_word.beat.name(), head_word.is_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PFD;
    cfg_wdata      = '0;
    fail_count     = 0;
    hold_left      = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 45;
    pfd_shadow     = 10'd250;
    r1_base_shadow = 32'd32769;
    r4_on_shadow   = 32'd9207868;
    rf_off_shadow  = 32'd9207836;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clamp_and_dividers();
    test_pfd_extremes();
    test_base_words();
    test_output_hold();
    test_random_traffic(105, 19, 45);
    test_random_traffic(105, 45, 19);
    test_random_traffic(105, 0, 0);

    // anything extra coming out after the drain is flagged by the checker
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
